FILE: hdl/min_heap_timer_queue_top_assert.svh
// Assertion macros for the timer queue top level.
// Used by min_heap_timer_queue_top; expects clk and rst in scope.
`ifndef MIN_HEAP_TIMER_QUEUE_TOP_ASSERT_SVH
`define MIN_HEAP_TIMER_QUEUE_TOP_ASSERT_SVH

// same-cycle implication
`define MHTQ_CHECK_NOW(name, cond, conseq, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// next-cycle implication
`define MHTQ_CHECK_NEXT(name, cond, conseq, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

FILE: hdl/mhtq_pkg.sv
// Shared types and codes for the min-heap timer queue.
// No dependencies.
`timescale 1ns / 1ps
package mhtq_pkg;
  localparam int ID_W      = 6;
  localparam int ID_COUNT  = 64;
  localparam int KIND_W    = 2;
  localparam int STAT_W    = 2;
  localparam int IN_TIME_W = 32;

  localparam logic [KIND_W-1:0] K_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] K_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] K_ADJUST = 2'd2;
  localparam logic [KIND_W-1:0] K_TICK   = 2'd3;

  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EXPIRED = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STAT_W-1:0] ST_INVALID = 2'd3;

  // heap read address select
  localparam logic [2:0] RD_ROOT   = 3'd0;
  localparam logic [2:0] RD_TAIL   = 3'd1;
  localparam logic [2:0] RD_PARENT = 3'd2;
  localparam logic [2:0] RD_LCHILD = 3'd3;
  localparam logic [2:0] RD_RCHILD = 3'd4;

  // datapath operations
  localparam logic [3:0] OP_NONE  = 4'd0;
  localparam logic [3:0] OP_INS   = 4'd1;
  localparam logic [3:0] OP_DEL   = 4'd2;
  localparam logic [3:0] OP_ADJ   = 4'd3;
  localparam logic [3:0] OP_POP   = 4'd4;
  localparam logic [3:0] OP_TAIL  = 4'd5;
  localparam logic [3:0] OP_UPMV  = 4'd6;
  localparam logic [3:0] OP_DNL   = 4'd7;
  localparam logic [3:0] OP_DNR   = 4'd8;
  localparam logic [3:0] OP_DNMV  = 4'd9;
  localparam logic [3:0] OP_PLACE = 4'd10;

  typedef struct packed {
    logic       latch;
    logic [2:0] rd_sel;
    logic [3:0] op;
  } cmd_t;

  typedef struct packed {
    logic              slot_nz;
    logic              slot_ok;
    logic              full;
    logic              del_tail;
    logic              root_tail;
    logic              pos_zero;
    logic              up_gt;
    logic              has_child;
    logic              has_right;
    logic              dn_gt;
    logic              moved;
    logic              tick_more;
    logic              pops_zero;
    logic [KIND_W-1:0] req_kind;
    logic [ID_W-1:0]   req_id;
    logic [ID_W-1:0]   pop_id;
  } sts_t;
endpackage

FILE: hdl/mhtq_if.sv
// Request and result channel interfaces for the timer queue.
// Depends on mhtq_pkg.
`timescale 1ns / 1ps
interface mhtq_req_if import mhtq_pkg::*; ;
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [ID_W-1:0]      timer_id;
  logic [IN_TIME_W-1:0] expire_time;
  logic [IN_TIME_W-1:0] current_time;
  modport source (output valid, kind, timer_id, expire_time, current_time, input ready);
  modport sink (input valid, kind, timer_id, expire_time, current_time, output ready);
endinterface

interface mhtq_res_if import mhtq_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   result_id;
  logic [STAT_W-1:0] status;
  logic              last;
  modport source (output valid, result_id, status, last, input ready);
  modport sink (input valid, result_id, status, last, output ready);
endinterface

FILE: hdl/mhtq_ctrl.sv
// Sequencing FSM for the timer queue: decodes requests, steps sifts, drives results.
// Depends on mhtq_pkg and mhtq_if.
`timescale 1ns / 1ps
module mhtq_ctrl import mhtq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  mhtq_req_if.sink    req,
  mhtq_res_if.source  res,
  output cmd_t        cmd,
  input  sts_t        sts
);
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_LOAD    = 4'd1;
  localparam logic [3:0] S_CHECK   = 4'd2;
  localparam logic [3:0] S_TAIL_RD = 4'd3;
  localparam logic [3:0] S_TAIL_LD = 4'd4;
  localparam logic [3:0] S_UP      = 4'd5;
  localparam logic [3:0] S_UP_CMP  = 4'd6;
  localparam logic [3:0] S_DN      = 4'd7;
  localparam logic [3:0] S_DN_L    = 4'd8;
  localparam logic [3:0] S_DN_R    = 4'd9;
  localparam logic [3:0] S_DN_CMP  = 4'd10;
  localparam logic [3:0] S_PLACE   = 4'd11;
  localparam logic [3:0] S_RES     = 4'd12;
  localparam logic [3:0] S_T_RD    = 4'd13;
  localparam logic [3:0] S_T_CHK   = 4'd14;

  logic [3:0]        state, state_next;
  logic [STAT_W-1:0] res_code, res_code_next;
  logic              res_valid;
  logic [ID_W-1:0]   res_id;
  logic [STAT_W-1:0] res_stat;
  logic              res_last;
  logic              can_emit;
  logic              emit;
  logic [ID_W-1:0]   em_id;
  logic [STAT_W-1:0] em_stat;
  logic              em_last;

  assign can_emit = !res_valid || res.ready;
  assign req.ready = (state == S_IDLE);
  assign res.valid = res_valid;
  assign res.result_id = res_id;
  assign res.status = res_stat;
  assign res.last = res_last;

  always_comb begin
    state_next = state;
    res_code_next = res_code;
    cmd = '{latch: 1'b0, rd_sel: RD_ROOT, op: OP_NONE};
    emit = 1'b0;
    em_id = sts.req_id;
    em_stat = res_code;
    em_last = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          cmd.latch = 1'b1;
          state_next = S_LOAD;
        end
      end
      S_LOAD: state_next = S_CHECK;
      S_CHECK: begin
        unique case (sts.req_kind)
          K_INSERT: begin
            if (sts.slot_nz) begin
              res_code_next = ST_INVALID;
              state_next = S_RES;
            end else if (sts.full) begin
              res_code_next = ST_FULL;
              state_next = S_RES;
            end else begin
              cmd.op = OP_INS;
              state_next = S_UP;
            end
          end
          K_DELETE: begin
            if (!sts.slot_ok) begin
              res_code_next = ST_INVALID;
              state_next = S_RES;
            end else begin
              cmd.op = OP_DEL;
              if (sts.del_tail) begin
                res_code_next = ST_DONE;
                state_next = S_RES;
              end else begin
                state_next = S_TAIL_RD;
              end
            end
          end
          K_ADJUST: begin
            if (!sts.slot_ok) begin
              res_code_next = ST_INVALID;
              state_next = S_RES;
            end else begin
              cmd.op = OP_ADJ;
              state_next = S_UP;
            end
          end
          default: state_next = S_T_CHK;
        endcase
      end
      S_TAIL_RD: begin
        cmd.rd_sel = RD_TAIL;
        state_next = S_TAIL_LD;
      end
      S_TAIL_LD: begin
        cmd.op = OP_TAIL;
        state_next = S_UP;
      end
      S_UP: begin
        if (sts.pos_zero) begin
          state_next = sts.moved ? S_PLACE : S_DN;
        end else begin
          cmd.rd_sel = RD_PARENT;
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        cmd.rd_sel = RD_PARENT;
        if (sts.up_gt) begin
          cmd.op = OP_UPMV;
          state_next = S_UP;
        end else begin
          state_next = sts.moved ? S_PLACE : S_DN;
        end
      end
      S_DN: begin
        if (!sts.has_child) begin
          state_next = S_PLACE;
        end else begin
          cmd.rd_sel = RD_LCHILD;
          state_next = S_DN_L;
        end
      end
      S_DN_L: begin
        cmd.op = OP_DNL;
        if (sts.has_right) begin
          cmd.rd_sel = RD_RCHILD;
          state_next = S_DN_R;
        end else begin
          state_next = S_DN_CMP;
        end
      end
      S_DN_R: begin
        cmd.op = OP_DNR;
        state_next = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (sts.dn_gt) begin
          cmd.op = OP_DNMV;
          state_next = S_DN;
        end else begin
          state_next = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd.op = OP_PLACE;
        if (sts.req_kind == K_TICK) begin
          state_next = S_T_RD;
        end else begin
          res_code_next = ST_DONE;
          state_next = S_RES;
        end
      end
      S_RES: begin
        if (can_emit) begin
          emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_T_RD: state_next = S_T_CHK;
      S_T_CHK: begin
        // the previous pop's beat goes out together with the next pop
        if (can_emit) begin
          if (sts.tick_more) begin
            emit = !sts.pops_zero;
            em_id = sts.pop_id;
            em_stat = ST_EXPIRED;
            em_last = 1'b0;
            cmd.op = OP_POP;
            state_next = sts.root_tail ? S_T_RD : S_TAIL_RD;
          end else begin
            emit = 1'b1;
            em_id = sts.pops_zero ? '0 : sts.pop_id;
            em_stat = sts.pops_zero ? ST_DONE : ST_EXPIRED;
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res_valid <= 1'b0;
      res_code <= ST_DONE;
    end else begin
      state <= state_next;
      res_code <= res_code_next;
      if (emit) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_id <= em_id;
      res_stat <= em_stat;
      res_last <= em_last;
    end
  end
endmodule

FILE: hdl/mhtq_dp.sv
// Datapath for the timer queue: heap memory, id-to-slot map, sift registers.
// Depends on mhtq_pkg and mhtq_if.
`timescale 1ns / 1ps
module mhtq_dp import mhtq_pkg::*; #(
  parameter int CAPACITY  = 64,
  parameter int TIME_BITS = 32
) (
  input  logic     clk,
  input  logic     rst,
  mhtq_req_if.sink req,
  input  cmd_t     cmd,
  output sts_t     sts
);
  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int SLOT_W = $clog2(CAPACITY + 1);
  localparam int CH_W   = IDX_W + 1;
  localparam int ENT_W  = ID_W + TIME_BITS;

  logic [KIND_W-1:0]    req_kind;
  logic [ID_W-1:0]      req_id;
  logic [TIME_BITS-1:0] req_exp;
  logic [TIME_BITS-1:0] req_now;
  logic [ENT_W-1:0]     ent;
  logic [ENT_W-1:0]     cand;
  logic [IDX_W-1:0]     pos;
  logic [IDX_W-1:0]     cidx;
  logic [SLOT_W-1:0]    count;
  logic                 moved;
  logic [ID_W:0]        pops;
  logic [ID_W-1:0]      pop_id;

  logic [ENT_W-1:0]  heap_mem [CAPACITY];
  logic [ENT_W-1:0]  heap_q;
  logic [IDX_W-1:0]  heap_ra;
  logic              heap_we;
  logic [IDX_W-1:0]  heap_wa;
  logic [ENT_W-1:0]  heap_wd;

  logic [SLOT_W-1:0] slot_mem [ID_COUNT];
  logic [ID_COUNT-1:0] slot_vld;
  logic [SLOT_W-1:0] slot_q;
  logic              slot_we;
  logic [ID_W-1:0]   slot_wa;
  logic [SLOT_W-1:0] slot_wd;

  logic [CH_W-1:0]      child;
  logic [CH_W-1:0]      child_r;
  logic [IDX_W-1:0]     parent;
  logic [SLOT_W-1:0]    pos_slot;
  logic [TIME_BITS-1:0] q_exp, ent_exp, cand_exp;
  logic [ID_W-1:0]      q_id, ent_id, cand_id;

  assign child    = {pos, 1'b1};
  assign child_r  = child + CH_W'(1);
  assign parent   = IDX_W'((pos - IDX_W'(1)) >> 1);
  assign pos_slot = SLOT_W'(pos) + SLOT_W'(1);
  assign q_exp    = heap_q[TIME_BITS-1:0];
  assign q_id     = heap_q[ENT_W-1:TIME_BITS];
  assign ent_exp  = ent[TIME_BITS-1:0];
  assign ent_id   = ent[ENT_W-1:TIME_BITS];
  assign cand_exp = cand[TIME_BITS-1:0];
  assign cand_id  = cand[ENT_W-1:TIME_BITS];

  always_comb begin
    unique case (cmd.rd_sel)
      RD_TAIL:   heap_ra = count[IDX_W-1:0];
      RD_PARENT: heap_ra = parent;
      RD_LCHILD: heap_ra = child[IDX_W-1:0];
      RD_RCHILD: heap_ra = child_r[IDX_W-1:0];
      default:   heap_ra = '0;
    endcase
  end

  always_comb begin
    heap_we = 1'b0;
    heap_wa = pos;
    heap_wd = ent;
    slot_we = 1'b0;
    slot_wa = ent_id;
    slot_wd = pos_slot;
    case (cmd.op)
      OP_DEL: begin
        slot_we = 1'b1;
        slot_wa = req_id;
        slot_wd = '0;
      end
      OP_POP: begin
        slot_we = 1'b1;
        slot_wa = q_id;
        slot_wd = '0;
      end
      OP_UPMV: begin
        heap_we = 1'b1;
        heap_wd = heap_q;
        slot_we = 1'b1;
        slot_wa = q_id;
      end
      OP_DNMV: begin
        heap_we = 1'b1;
        heap_wd = cand;
        slot_we = 1'b1;
        slot_wa = cand_id;
      end
      OP_PLACE: begin
        heap_we = 1'b1;
        slot_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (heap_we) begin
      heap_mem[heap_wa] <= heap_wd;
    end
    heap_q <= heap_mem[heap_ra];
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    slot_q <= slot_vld[req_id] ? slot_mem[req_id] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_vld <= '0;
    end else if (slot_we) begin
      slot_vld[slot_wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      pops <= '0;
      moved <= 1'b0;
    end else begin
      if (cmd.latch) begin
        pops <= '0;
      end
      case (cmd.op)
        OP_INS: begin
          count <= count + SLOT_W'(1);
          moved <= 1'b0;
        end
        OP_DEL, OP_ADJ: moved <= 1'b0;
        OP_POP: begin
          count <= count - SLOT_W'(1);
          pops <= pops + (ID_W+1)'(1);
          moved <= 1'b0;
        end
        OP_UPMV: moved <= 1'b1;
        default: ;
      endcase
      if (cmd.op == OP_DEL) begin
        count <= count - SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_kind <= req.kind;
      req_id <= req.timer_id;
      req_exp <= TIME_BITS'(req.expire_time);
      req_now <= TIME_BITS'(req.current_time);
    end
    case (cmd.op)
      OP_INS: begin
        ent <= {req_id, req_exp};
        pos <= count[IDX_W-1:0];
      end
      OP_DEL: pos <= IDX_W'(slot_q - SLOT_W'(1));
      OP_ADJ: begin
        ent <= {req_id, req_exp};
        pos <= IDX_W'(slot_q - SLOT_W'(1));
      end
      OP_POP: begin
        pop_id <= q_id;
        pos <= '0;
      end
      OP_TAIL: ent <= heap_q;
      OP_UPMV: pos <= parent;
      OP_DNL: begin
        cand <= heap_q;
        cidx <= child[IDX_W-1:0];
      end
      OP_DNR: begin
        // right child wins only when strictly earlier
        if (cand_exp > q_exp) begin
          cand <= heap_q;
          cidx <= child_r[IDX_W-1:0];
        end
      end
      OP_DNMV: pos <= cidx;
      default: ;
    endcase
  end

  always_comb begin
    sts.slot_nz   = (slot_q != '0);
    sts.slot_ok   = (slot_q != '0) && (slot_q <= count);
    sts.full      = (count == SLOT_W'(CAPACITY));
    sts.del_tail  = (slot_q == count);
    sts.root_tail = (count == SLOT_W'(1));
    sts.pos_zero  = (pos == '0);
    sts.up_gt     = (q_exp > ent_exp);
    sts.has_child = (child < CH_W'(count));
    sts.has_right = (child_r < CH_W'(count));
    sts.dn_gt     = (ent_exp > cand_exp);
    sts.moved     = moved;
    sts.tick_more = (count != '0) && (q_exp < req_now) && !pops[ID_W];
    sts.pops_zero = (pops == '0);
    sts.req_kind  = req_kind;
    sts.req_id    = req_id;
    sts.pop_id    = pop_id;
  end
endmodule

FILE: hdl/min_heap_timer_queue_top.sv
// Timer queue: binary min-heap on expiry with an id-to-slot map.
// Request beats on req: kind (insert, delete, adjust, tick), timer_id, expire_time,
// current_time. Result beats on res: result_id, status, last.
// Insert, delete and adjust give one beat with last set. A tick gives one expired
// beat per timer whose expiry is strictly before current_time, in pop order, the
// final one with last set; with nothing expired it gives a single done beat for id 0.
// One request is worked at a time: req.ready is high only while idle. A rejected
// request, or a delete of the last entry, goes from the check straight to the
// result. Every sift step is a registered read of the heap memory, which has one
// read and one write port: each level going up reads the parent, each level going
// down reads the left child and, if there is one, the right child. A tick pops
// expired timers one at a time and restores the heap after each pop.
// Results sit in an output register; a new request may be accepted while the final
// beat of the last one waits. A stalled res holds the sequencer mid-tick.
// Reset (rst, synchronous) empties the heap and clears the slot map.
`timescale 1ns / 1ps
module min_heap_timer_queue_top import mhtq_pkg::*; #(
  parameter int CAPACITY  = 64,
  parameter int TIME_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  mhtq_req_if.sink   req,
  mhtq_res_if.source res
);
  cmd_t cmd;
  sts_t sts;

  mhtq_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .req (req),
    .res (res),
    .cmd (cmd),
    .sts (sts)
  );

  mhtq_dp #(
    .CAPACITY  (CAPACITY),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .sts (sts)
  );

`include "min_heap_timer_queue_top_assert.svh"

  `MHTQ_CHECK_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready, "ready after accept")
  `MHTQ_CHECK_NOW(a_mid_tick_busy, res.valid && !res.last, !req.ready, "idle mid tick")
  `MHTQ_CHECK_NOW(a_nonlast_expired, res.valid && !res.last, res.status == ST_EXPIRED, "bad status")
endmodule
